/* design/ps2acc_pkg.sv */
// Shared types, constants and arithmetic helpers for the PS/2 mouse packet accumulator.
package ps2acc_pkg;

    localparam int ACC_WIDTH    = 16;
    localparam int REPORT_WIDTH = 16;
    localparam int BUTTON_WIDTH = 3;
    localparam int DELTA_WIDTH  = 10;
    localparam int CMP_WIDTH    = (ACC_WIDTH > REPORT_WIDTH) ? ACC_WIDTH : REPORT_WIDTH;

    localparam int HDR_SYNC_BIT   = 3;
    localparam int HDR_X_SIGN_BIT = 4;
    localparam int HDR_Y_SIGN_BIT = 5;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        SLOT_HEADER = 3'b001,
        SLOT_X      = 3'b010,
        SLOT_Y      = 3'b100
    } t_slot;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic signed [REPORT_WIDTH-1:0] motion_x;
        logic signed [REPORT_WIDTH-1:0] motion_y;
        logic [BUTTON_WIDTH-1:0]        button_bits;
        logic                           fresh;
    } t_out;

    typedef struct packed {
        logic       go;
        logic       operation;
        logic [7:0] data_byte;
    } t_step;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0]   acc,
        input logic signed [DELTA_WIDTH-1:0] delta
    );
        logic signed [ACC_WIDTH:0] sum;
        sum = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(delta);
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
            return sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return sum[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [REPORT_WIDTH-1:0] report_clamp(
        input logic signed [ACC_WIDTH-1:0] value
    );
        logic signed [CMP_WIDTH-1:0] wide;
        logic signed [CMP_WIDTH-1:0] lim_max;
        logic signed [CMP_WIDTH-1:0] lim_min;
        wide    = CMP_WIDTH'(value);
        lim_max = CMP_WIDTH'({1'b0, {(REPORT_WIDTH-1){1'b1}}});
        lim_min = -lim_max - CMP_WIDTH'(1);
        if (wide > lim_max) begin
            wide = lim_max;
        end else if (wide < lim_min) begin
            wide = lim_min;
        end
        return wide[REPORT_WIDTH-1:0];
    endfunction

endpackage

/* design/ps2acc_motion.sv */
// Packet assembly, motion accumulation and button latching for one transaction per cycle.
module ps2acc_motion (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2acc_pkg::t_step   i_step,
    output ps2acc_pkg::t_out    o_report
);

    ps2acc_pkg::t_slot r_slot, n_slot;
    logic [7:0] r_header, n_header;
    logic [7:0] r_x_byte, n_x_byte;
    logic signed [ps2acc_pkg::ACC_WIDTH-1:0] r_sum_x, n_sum_x;
    logic signed [ps2acc_pkg::ACC_WIDTH-1:0] r_sum_y, n_sum_y;
    logic [ps2acc_pkg::BUTTON_WIDTH-1:0] r_buttons, n_buttons;
    logic r_changed, n_changed;

    logic signed [8:0] dx9;
    logic signed [8:0] dy9;
    logic signed [ps2acc_pkg::DELTA_WIDTH-1:0] dx_ext;
    logic signed [ps2acc_pkg::DELTA_WIDTH-1:0] neg_dy;

    assign dx9    = $signed({r_header[ps2acc_pkg::HDR_X_SIGN_BIT], r_x_byte});
    assign dy9    = $signed({r_header[ps2acc_pkg::HDR_Y_SIGN_BIT], i_step.data_byte});
    assign dx_ext = ps2acc_pkg::DELTA_WIDTH'(dx9);
    assign neg_dy = -ps2acc_pkg::DELTA_WIDTH'(dy9);

    always_comb begin
        n_slot    = r_slot;
        n_header  = r_header;
        n_x_byte  = r_x_byte;
        n_sum_x   = r_sum_x;
        n_sum_y   = r_sum_y;
        n_buttons = r_buttons;
        n_changed = r_changed;
        if (i_step.go) begin
            if (i_step.operation == ps2acc_pkg::OP_READ) begin
                n_sum_x   = '0;
                n_sum_y   = '0;
                n_changed = 1'b0;
            end else begin
                unique case (r_slot)
                    ps2acc_pkg::SLOT_HEADER: begin
                        if (i_step.data_byte[ps2acc_pkg::HDR_SYNC_BIT]) begin
                            n_header = i_step.data_byte;
                            n_slot   = ps2acc_pkg::SLOT_X;
                        end
                    end
                    ps2acc_pkg::SLOT_X: begin
                        n_x_byte = i_step.data_byte;
                        n_slot   = ps2acc_pkg::SLOT_Y;
                    end
                    default: begin
                        n_sum_x   = ps2acc_pkg::sat_add(r_sum_x, dx_ext);
                        n_sum_y   = ps2acc_pkg::sat_add(r_sum_y, neg_dy);
                        n_buttons = r_header[ps2acc_pkg::BUTTON_WIDTH-1:0];
                        n_changed = 1'b1;
                        n_slot    = ps2acc_pkg::SLOT_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= ps2acc_pkg::SLOT_HEADER;
            r_header  <= '0;
            r_x_byte  <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_buttons <= '0;
            r_changed <= 1'b0;
        end else begin
            r_slot    <= n_slot;
            r_header  <= n_header;
            r_x_byte  <= n_x_byte;
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_buttons <= n_buttons;
            r_changed <= n_changed;
        end
    end

    always_comb begin
        o_report.motion_x    = ps2acc_pkg::report_clamp(r_sum_x);
        o_report.motion_y    = ps2acc_pkg::report_clamp(r_sum_y);
        o_report.button_bits = r_buttons;
        o_report.fresh       = r_changed;
    end

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.go && i_step.operation == ps2acc_pkg::OP_READ
        |=> !r_changed && r_sum_x == '0 && r_sum_y == '0)
        else $error("read did not clear the accumulated motion");

    a_out_of_sync_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.go && i_step.operation == ps2acc_pkg::OP_BYTE
        && r_slot == ps2acc_pkg::SLOT_HEADER && !i_step.data_byte[ps2acc_pkg::HDR_SYNC_BIT]
        |=> r_slot == ps2acc_pkg::SLOT_HEADER && $stable(r_header))
        else $error("header without sync bit was not dropped");

    a_packet_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.go && i_step.operation == ps2acc_pkg::OP_BYTE && r_slot == ps2acc_pkg::SLOT_Y
        |=> r_changed && r_slot == ps2acc_pkg::SLOT_HEADER
            && r_buttons == $past(r_header[ps2acc_pkg::BUTTON_WIDTH-1:0]))
        else $error("completed packet did not update buttons and flag");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step.go |=> $stable(r_slot) && $stable(r_sum_x) && $stable(r_sum_y)
                       && $stable(r_changed))
        else $error("state changed without a transaction");

endmodule

/* design/ps2_mouse_packet_accumulator.sv */
// Top level of the PS/2 mouse packet accumulator with input and result registers.
//
// Usage: each input transaction carries an operation and a data byte. Operation
// byte feeds one received mouse byte into the three-byte packet assembler and
// produces no result. Operation read produces one result transaction holding the
// saturated X and Y motion, the latest buttons and the fresh flag, and then clears
// the motion sums and the flag.
// A read passes through the input register and then the result register before its
// result is valid on the result channel. Throughput is one transaction per cycle
// while no read waits behind a held result: the input register and the single-pass
// update in the motion unit take a new transaction every cycle otherwise.
// When the receiver stalls, the pending result holds in the result register. Byte
// transactions keep flowing; a read waiting behind the held result stalls the input
// channel until the result register frees up.
// Reset clears the packet position, the motion sums, the buttons, the flag and both
// valid bits; no transaction is accepted during reset.
module ps2_mouse_packet_accumulator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ps2acc_pkg::t_in   i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output ps2acc_pkg::t_out  o_result
);

    logic              r_in_vld;
    ps2acc_pkg::t_in   r_in;
    logic              r_out_vld;
    ps2acc_pkg::t_out  r_out;
    logic              out_free;
    logic              is_read;
    logic              go;
    ps2acc_pkg::t_step step;
    ps2acc_pkg::t_out  report;

    assign out_free = !r_out_vld || !i_stall;
    assign is_read  = r_in.operation == ps2acc_pkg::OP_READ;
    assign go       = r_in_vld && (!is_read || out_free);
    assign o_stall  = r_in_vld && !go;

    always_comb begin
        step.go        = go;
        step.operation = r_in.operation;
        step.data_byte = r_in.data_byte;
    end

    ps2acc_motion u_motion (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_report (report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (go && is_read) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_item;
        end
        if (go && is_read) begin
            r_out <= report;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

/* tb/tb_ps2_mouse_packet_accumulator.sv */
// Self-checking testbench for the PS/2 mouse packet accumulator: directed and random tests.
module tb_ps2_mouse_packet_accumulator;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_IDLE       = 8;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     MAX_PRINTED    = 40;
    localparam longint SIGN_WEIGHT    = 256;
    localparam longint ACC_HI         = (64'sd1 <<< (ps2acc_pkg::ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO         = -ACC_HI - 1;
    localparam longint REPORT_HI      = (64'sd1 <<< (ps2acc_pkg::REPORT_WIDTH - 1)) - 1;
    localparam longint REPORT_LO      = -REPORT_HI - 1;
    localparam logic [7:0] SYNC_MASK  = 8'(1 << ps2acc_pkg::HDR_SYNC_BIT);
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_X      = 2'd1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    ps2acc_pkg::t_in  i_item;
    logic o_valid;
    logic i_stall;
    ps2acc_pkg::t_out o_result;

    // Shadow state of the packet assembler and the motion sums.
    logic [1:0] pkt_pos       = POS_HEADER;
    logic [7:0] pkt_header    = '0;
    logic [7:0] pkt_x         = '0;
    longint     motion_sum_x  = 0;
    longint     motion_sum_y  = 0;
    logic [2:0] held_btn      = '0;
    logic       packet_seen   = 1'b0;
    ps2acc_pkg::t_out pending_reports[$];

    int   mismatch_count  = 0;
    int   items_sent      = 0;
    int   reports_checked = 0;
    int   idle_cycles     = 0;
    int   rx_wait         = 0;
    logic rx_hold         = 1'b0;
    logic rx_calm         = 1'b0;
    logic tx_calm         = 1'b0;

    ps2_mouse_packet_accumulator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic int pick_gap(input logic calm);
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic void accumulate_mouse_item(input ps2acc_pkg::t_in item);
        ps2acc_pkg::t_out rep;
        longint dx;
        longint dy;
        if (item.operation == ps2acc_pkg::OP_READ) begin
            rep.motion_x    = ps2acc_pkg::REPORT_WIDTH'(
                clamp_range(motion_sum_x, REPORT_LO, REPORT_HI));
            rep.motion_y    = ps2acc_pkg::REPORT_WIDTH'(
                clamp_range(motion_sum_y, REPORT_LO, REPORT_HI));
            rep.button_bits = held_btn;
            rep.fresh       = packet_seen;
            pending_reports.push_back(rep);
            motion_sum_x = 0;
            motion_sum_y = 0;
            packet_seen  = 1'b0;
        end else if (pkt_pos == POS_HEADER) begin
            if (item.data_byte[ps2acc_pkg::HDR_SYNC_BIT]) begin
                pkt_header = item.data_byte;
                pkt_pos    = POS_X;
            end
        end else if (pkt_pos == POS_X) begin
            pkt_x   = item.data_byte;
            pkt_pos = pkt_pos + 2'd1;
        end else begin
            dx = longint'(pkt_x)
                 - (pkt_header[ps2acc_pkg::HDR_X_SIGN_BIT] ? SIGN_WEIGHT : 0);
            dy = longint'(item.data_byte)
                 - (pkt_header[ps2acc_pkg::HDR_Y_SIGN_BIT] ? SIGN_WEIGHT : 0);
            motion_sum_x = clamp_range(motion_sum_x + dx, ACC_LO, ACC_HI);
            motion_sum_y = clamp_range(motion_sum_y - dy, ACC_LO, ACC_HI);
            held_btn     = pkt_header[2:0];
            packet_seen  = 1'b1;
            pkt_pos      = POS_HEADER;
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] data);
        ps2acc_pkg::t_in item;
        int  gap;
        item.operation = op;
        item.data_byte = data;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_stall);
        accumulate_mouse_item(item);
        items_sent++;
    endtask

    task automatic send_read();
        send_item(ps2acc_pkg::OP_READ, 8'($urandom));
    endtask

    task automatic send_packet(input logic [7:0] header, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_item(ps2acc_pkg::OP_BYTE, header);
        send_item(ps2acc_pkg::OP_BYTE, dx);
        send_item(ps2acc_pkg::OP_BYTE, dy);
    endtask

    task automatic wait_reports_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic test_directed();
        send_read();
        send_item(ps2acc_pkg::OP_BYTE, 8'h00);
        send_item(ps2acc_pkg::OP_BYTE, 8'hF7);
        send_packet(8'h08, 8'h00, 8'h00);
        send_read();
        send_packet(8'h3F, 8'h00, 8'h00);
        send_read();
        send_packet(8'h0F, 8'hFF, 8'hFF);
        send_read();
        send_item(ps2acc_pkg::OP_BYTE, 8'h2A);
        send_read();
        send_item(ps2acc_pkg::OP_BYTE, 8'h80);
        send_read();
        send_item(ps2acc_pkg::OP_BYTE, 8'h7F);
        send_read();
        send_read();
    endtask

    task automatic test_saturation();
        tx_calm = 1'b1;
        repeat (130) send_packet(8'h28, 8'hFF, 8'h00);
        send_read();
        tx_calm = 1'b0;
        repeat (130) send_packet(8'h18, 8'h00, 8'hFF);
        repeat (4) send_packet(8'h08, 8'h10, 8'h01);
        send_read();
    endtask

    task automatic test_random_packets(input int rounds);
        int pick;
        repeat (rounds) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0) begin
                tx_calm = ~tx_calm;
            end
            if (pick < 65) begin
                send_packet(8'($urandom) | SYNC_MASK, 8'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                send_read();
            end else if (pick < 93) begin
                send_item(ps2acc_pkg::OP_BYTE, 8'($urandom));
            end else begin
                send_item(ps2acc_pkg::OP_BYTE, 8'($urandom) | SYNC_MASK);
                send_read();
            end
        end
        tx_calm = 1'b0;
    endtask

    task automatic test_backpressure();
        tx_calm = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            repeat (20) begin
                send_packet(8'($urandom) | SYNC_MASK, 8'($urandom), 8'($urandom));
                send_read();
            end
        join
        tx_calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            test_random_packets(10);
            send_read();
            wait_reports_drained();
        end
    endtask

    always @(posedge i_clk) begin : report_check
        ps2acc_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("report with none expected", 1, 0);
            end else begin
                want = pending_reports.pop_front();
                if (o_result.motion_x !== want.motion_x) begin
                    report_mismatch("motion_x", o_result.motion_x, want.motion_x);
                end
                if (o_result.motion_y !== want.motion_y) begin
                    report_mismatch("motion_y", o_result.motion_y, want.motion_y);
                end
                if (o_result.button_bits !== want.button_bits) begin
                    report_mismatch("button_bits", o_result.button_bits, want.button_bits);
                end
                if (o_result.fresh !== want.fresh) begin
                    report_mismatch("fresh", o_result.fresh, want.fresh);
                end
            end
            reports_checked++;
            if ($urandom_range(0, 31) == 0) begin
                rx_calm = ~rx_calm;
            end
            rx_wait = pick_gap(rx_calm);
        end
        if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= rx_hold;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d reports outstanding.", pending_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        i_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_saturation();
        test_random_packets(330);
        test_backpressure();
        test_drain_pause();

        wait_reports_drained();
        repeat (10) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            report_mismatch("reports never delivered", 0, pending_reports.size());
        end
        $display("Sent %0d transactions and checked %0d reports.", items_sent, reports_checked);
        $display("Covered resync drops, saturation both ways, split reads and a long hold-off.");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
